// ===== sv/celf_pkg.sv =====
package celf_pkg;

    localparam int PROB_W  = 56;
    localparam int CONF_W  = 64;
    localparam int LOSS_W  = 32;
    localparam int CLASS_W = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HIGH  = 2'd2;

    localparam logic [PROB_W-1:0] CLIP_LOW_RST  = 56'd429;
    localparam logic [PROB_W-1:0] CLIP_HIGH_RST = 56'd42949672960000000;

    // Depth of the row queue between the accumulator and the log engine.
    localparam int QUEUE_DEPTH = 4;

    // Fraction bits of log2 and ln(2) scaled by 2^30.
    localparam int LOG_FRAC_BITS = 28;
    localparam int LN2_W = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

    localparam logic [LOSS_W-1:0] LOSS_MAX = 32'h7FFF_FFFF;

endpackage

// ===== sv/cross_entropy_loss_forward.sv =====
// Categorical cross-entropy loss, forward pass, streamed one class per request.
// Input channel (s_*): one predicted probability per request, unsigned Q24.32,
// with its one-hot label bit, the true class index of the sample, and s_row_last
// on the final class of a sample. Each value is clipped to [clip_low, clip_high].
// Output channel (m_*): one result per sample, m_loss = -ln(confidence) as
// signed Q7.24; a zero confidence gives 0x7FFFFFFF with m_saturated set.
// Configuration channel (cfg_*): index 0 label_mode, 1 clip_low, 2 clip_high;
// writes are always taken and are meant for an idle block.
// Throughput: one input request per cycle while the queue can take row ends. The
// front end clips and accumulates in a two-stage pipeline and hands each finished
// row confidence to a four-entry queue. For each row the log engine takes it from
// the queue, runs six steps of leading-one search and 28 squaring steps on one
// 32x32 multiplier, then passes through its log, scale, round and output states. Rows
// that take the front end at least as long as a row takes the engine stream at full
// rate; shorter rows are held to the engine's pace once the queue fills. A zero
// confidence skips straight from the queue to the output state.
// Reset clears the row state, the queue and the output valid flag and restores the
// configuration defaults. A stalled receiver holds the result in the output
// register; the engine can finish the next row and then waits, while the queue
// keeps filling. s_ready drops only when the queue is full and a row end is waiting.
module cross_entropy_loss_forward #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [celf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [celf_pkg::PROB_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [celf_pkg::PROB_W-1:0]       s_prob,
    input  logic                              s_label_bit,
    input  logic [celf_pkg::CLASS_W-1:0]      s_true_class,
    input  logic                              s_row_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [celf_pkg::LOSS_W-1:0] m_loss,
    output logic                              m_saturated
);
    import celf_pkg::*;

    logic              q_push;
    logic [CONF_W-1:0] q_push_conf;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    logic [CONF_W-1:0] q_head_conf;
    logic [LOSS_W-1:0] loss_bits;

    // Front end: configuration registers, clipping and per-row accumulation.
    celf_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_prob       (s_prob),
        .s_label_bit  (s_label_bit),
        .s_true_class (s_true_class),
        .s_row_last   (s_row_last),
        .q_push       (q_push),
        .q_conf       (q_push_conf),
        .q_full       (q_full)
    );

    // Row confidences wait here so the front end keeps streaming while the
    // log engine works on an earlier row.
    celf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_conf),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head_conf)
    );

    // Back end: iterative -ln evaluation and the output register.
    celf_log_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_conf      (q_head_conf),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_loss      (loss_bits),
        .m_saturated (m_saturated)
    );

    assign m_loss = signed'(loss_bits);

endmodule

// ===== sv/celf_front.sv =====
module celf_front #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [celf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [celf_pkg::PROB_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [celf_pkg::PROB_W-1:0]       s_prob,
    input  logic                              s_label_bit,
    input  logic [celf_pkg::CLASS_W-1:0]      s_true_class,
    input  logic                              s_row_last,
    output logic                              q_push,
    output logic [celf_pkg::CONF_W-1:0]       q_conf,
    input  logic                              q_full
);
    import celf_pkg::*;

    localparam int PW = $clog2(MAX_CLASSES + 1);
    localparam int CW = (PW > CLASS_W) ? PW : CLASS_W;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_CLASSES);

    logic              label_mode_reg;
    logic [PROB_W-1:0] clip_low_reg;
    logic [PROB_W-1:0] clip_high_reg;

    logic [PW-1:0]     pos_reg;
    logic              s1_valid_reg;
    logic [PROB_W-1:0] s1_prob_reg;
    logic              s1_take_reg;
    logic              s1_add_reg;
    logic              s1_last_reg;
    logic [CONF_W-1:0] sum_reg;

    logic [PROB_W-1:0] p_low;
    logic [PROB_W-1:0] p_clip;
    logic              match;
    logic              s_acc;
    logic              advance;
    logic [CONF_W:0]   sum_wide;
    logic [CONF_W-1:0] sum_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            label_mode_reg <= 1'b0;
            clip_low_reg   <= CLIP_LOW_RST;
            clip_high_reg  <= CLIP_HIGH_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_LABEL_MODE) begin
                label_mode_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_CLIP_LOW) begin
                clip_low_reg <= cfg_data;
            end
            if (cfg_index == CFG_CLIP_HIGH) begin
                clip_high_reg <= cfg_data;
            end
        end
    end

    // The lower bound applies first, so the upper bound wins when they cross.
    always_comb begin
        p_low  = (s_prob < clip_low_reg) ? clip_low_reg : s_prob;
        p_clip = (p_low > clip_high_reg) ? clip_high_reg : p_low;
        match  = (pos_reg != POS_MAX) && (CW'(pos_reg) == CW'(s_true_class));
    end

    assign advance = s1_valid_reg && !(s1_last_reg && q_full);
    assign s_ready = !s1_valid_reg || advance;
    assign s_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                if (s_row_last) begin
                    pos_reg <= '0;
                end else if (pos_reg != POS_MAX) begin
                    pos_reg <= pos_reg + 1'b1;
                end
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_prob_reg <= p_clip;
            s1_take_reg <= label_mode_reg ? s_label_bit : match;
            s1_add_reg  <= label_mode_reg;
            s1_last_reg <= s_row_last;
        end
    end

    always_comb begin
        sum_wide = {1'b0, sum_reg} + {{(CONF_W - PROB_W + 1){1'b0}}, s1_prob_reg};
        sum_next = sum_reg;
        if (s1_take_reg) begin
            if (s1_add_reg) begin
                sum_next = sum_wide[CONF_W] ? {CONF_W{1'b1}} : sum_wide[CONF_W-1:0];
            end else begin
                sum_next = {{(CONF_W - PROB_W){1'b0}}, s1_prob_reg};
            end
        end
    end

    assign q_push = advance && s1_last_reg;
    assign q_conf = sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (advance) begin
            sum_reg <= s1_last_reg ? '0 : sum_next;
        end
    end

endmodule

// ===== sv/celf_queue.sv =====
module celf_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [celf_pkg::CONF_W-1:0] push_data,
    output logic                        full,
    input  logic                        pop,
    output logic                        not_empty,
    output logic [celf_pkg::CONF_W-1:0] head_data
);
    import celf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [CONF_W-1:0] store [QUEUE_DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/celf_log_engine.sv =====
module celf_log_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_not_empty,
    input  logic [celf_pkg::CONF_W-1:0] q_conf,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [celf_pkg::LOSS_W-1:0] m_loss,
    output logic                        m_saturated
);
    import celf_pkg::*;

    localparam int SW  = $clog2(CONF_W);
    localparam int L2W = SW + LOG_FRAC_BITS;
    localparam int ITW = $clog2(LOG_FRAC_BITS);
    localparam int HALF = L2W / 2;

    typedef enum logic [2:0] {
        E_IDLE, E_NORM, E_SQUARE, E_LOG, E_SCALE, E_ROUND, E_DONE
    } eng_state_t;

    eng_state_t               state_reg;
    logic [CONF_W-1:0]        n_reg;
    logic [SW-1:0]            shift_reg;
    logic [2:0]               k_reg;
    logic [31:0]              m_reg;
    logic [ITW-1:0]           iter_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic                     sat_reg;
    logic                     pos_reg;
    logic [L2W-1:0]           l2mag_reg;
    logic [L2W-HALF+LN2_W-1:0] prod_hi_reg;
    logic [HALF+LN2_W-1:0]    prod_lo_reg;
    logic [LOSS_W-1:0]        res_reg;
    logic                     m_valid_reg;
    logic [LOSS_W-1:0]        m_loss_reg;
    logic                     m_sat_reg;

    logic                     zero_chunk;
    logic [CONF_W-1:0]        n_shifted;
    logic [SW-1:0]            shift_add;
    logic [63:0]              sq_prod;
    logic [32:0]              sq;
    logic [SW:0]              int_part;
    logic [L2W-1:0]           l2mag;
    logic [63:0]              total;
    logic [LOSS_W-1:0]        mag;

    // One step of the binary leading-one search: shift by 2^k when that many
    // top bits are all zero.
    always_comb begin
        unique case (k_reg)
            3'd5:    zero_chunk = (n_reg[63:32] == '0);
            3'd4:    zero_chunk = (n_reg[63:48] == '0);
            3'd3:    zero_chunk = (n_reg[63:56] == '0);
            3'd2:    zero_chunk = (n_reg[63:60] == '0);
            3'd1:    zero_chunk = (n_reg[63:62] == '0);
            default: zero_chunk = (n_reg[63] == 1'b0);
        endcase
        shift_add = zero_chunk ? (SW'(1) << k_reg) : '0;
        n_shifted = n_reg << shift_add;
    end

    always_comb begin
        sq_prod = {32'd0, m_reg} * {32'd0, m_reg};
        sq      = sq_prod[63:31];
    end

    // log2 magnitude: shift above 31 means confidence below one, positive loss.
    always_comb begin
        if (shift_reg > SW'(31)) begin
            int_part = (SW + 1)'(shift_reg) - (SW + 1)'(31);
            l2mag    = (L2W'(int_part) << LOG_FRAC_BITS) - L2W'(frac_reg);
        end else begin
            int_part = (SW + 1)'(31) - (SW + 1)'(shift_reg);
            l2mag    = (L2W'(int_part) << LOG_FRAC_BITS) + L2W'(frac_reg);
        end
    end

    always_comb begin
        total = ({prod_hi_reg, {HALF{1'b0}}} + 64'(prod_lo_reg)) + (64'd1 << 33);
        mag   = LOSS_W'(total[63:34]);
    end

    assign q_pop       = (state_reg == E_IDLE) && q_not_empty;
    assign m_valid     = m_valid_reg;
    assign m_loss      = m_loss_reg;
    assign m_saturated = m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == E_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                E_IDLE: begin
                    if (q_not_empty) begin
                        n_reg     <= q_conf;
                        shift_reg <= '0;
                        k_reg     <= 3'd5;
                        sat_reg   <= (q_conf == '0);
                        state_reg <= (q_conf == '0) ? E_DONE : E_NORM;
                    end
                end
                E_NORM: begin
                    n_reg     <= n_shifted;
                    shift_reg <= shift_reg | shift_add;
                    k_reg     <= k_reg - 1'b1;
                    if (k_reg == 3'd0) begin
                        m_reg     <= n_shifted[63:32];
                        iter_reg  <= '0;
                        frac_reg  <= '0;
                        state_reg <= E_SQUARE;
                    end
                end
                E_SQUARE: begin
                    m_reg    <= sq[32] ? sq[32:1] : sq[31:0];
                    frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq[32]};
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITW'(LOG_FRAC_BITS - 1)) begin
                        state_reg <= E_LOG;
                    end
                end
                E_LOG: begin
                    l2mag_reg <= l2mag;
                    pos_reg   <= (shift_reg > SW'(31));
                    state_reg <= E_SCALE;
                end
                E_SCALE: begin
                    prod_hi_reg <= l2mag_reg[L2W-1:HALF] * LN2_Q30;
                    prod_lo_reg <= l2mag_reg[HALF-1:0] * LN2_Q30;
                    state_reg   <= E_ROUND;
                end
                E_ROUND: begin
                    res_reg   <= pos_reg ? mag : (LOSS_W'(0) - mag);
                    state_reg <= E_DONE;
                end
                E_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_loss_reg  <= sat_reg ? LOSS_MAX : res_reg;
                        m_sat_reg   <= sat_reg;
                        state_reg   <= E_IDLE;
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/celf_checker.sv =====
module celf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [celf_pkg::LOSS_W-1:0] m_loss,
    input logic                              m_saturated
);
    import celf_pkg::*;

    // Reset empties the output register and reopens the input.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("output valid or input stall after reset");

    // A zero confidence always carries the clamp value.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_loss == signed'(LOSS_MAX)))
        else $error("saturated result without maximum loss");

    // A computed loss never exceeds about 22.2 in magnitude, so its top two
    // bits agree and it cannot alias the clamp value.
    a_loss_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_saturated) |-> (m_loss[31:30] == 2'b00 || m_loss[31:30] == 2'b11))
        else $error("computed loss out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_loss) && $stable(m_saturated)))
        else $error("result changed while stalled");

endmodule

bind cross_entropy_loss_forward celf_checker u_celf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_loss      (m_loss),
    .m_saturated (m_saturated)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the streaming cross-entropy loss block.
//
// A clocked driver feeds class requests from a pending queue that the main
// initial block fills phase by phase. At every accepted request the driver runs
// the bench's own scoring model, which clips the value, folds it into the row
// confidence and, at the end of a row, queues the expected loss. A clocked
// monitor pops that queue at every accepted result and compares it field by
// field. Configuration writes happen only when the block has drained, so the
// model's copy of the registers always matches the one the block is using.
module testbench;
    import celf_pkg::*;

    localparam int MAX_CLASSES   = 256;
    // This pause lets any row still in flight finish before a register write.
    localparam int SETTLE_CYCLES = 60;
    // Longest stretch with no request moving on any channel before giving up.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 12;

    localparam logic [PROB_W-1:0] PROB_MAX = {PROB_W{1'b1}};
    localparam logic [PROB_W-1:0] ONE_Q32  = 56'h1_0000_0000;

    typedef struct packed {
        logic [PROB_W-1:0]  prob;
        logic               label_bit;
        logic [CLASS_W-1:0] true_class;
        logic               row_last;
    } class_req_t;

    typedef struct packed {
        logic signed [LOSS_W-1:0] loss;
        logic                     saturated;
    } loss_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [PROB_W-1:0]         cfg_data  = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [PROB_W-1:0]         s_prob       = '0;
    logic                      s_label_bit  = 1'b0;
    logic [CLASS_W-1:0]        s_true_class = '0;
    logic                      s_row_last   = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [LOSS_W-1:0]  m_loss;
    logic                      m_saturated;

    // Requests waiting to be driven and losses waiting to come out.
    class_req_t class_req_q[$];
    loss_res_t  expected_loss_q[$];
    class_req_t cur_req;

    // The bench's copy of the registers and of the row state.
    logic              onehot_mode = 1'b0;
    logic [PROB_W-1:0] clip_lo     = CLIP_LOW_RST;
    logic [PROB_W-1:0] clip_hi     = CLIP_HIGH_RST;
    logic [CONF_W-1:0] row_conf    = '0;
    int                row_pos     = 0;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    int requests_sent   = 0;
    int rows_scored     = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int fail_count      = 0;
    int quiet_cycles    = 0;

    cross_entropy_loss_forward #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_prob      (s_prob),
        .s_label_bit (s_label_bit),
        .s_true_class(s_true_class),
        .s_row_last  (s_row_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_loss      (m_loss),
        .m_saturated (m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // -ln(conf) in signed Q7.24 for a nonzero Q32.32 confidence. The mantissa
    // is taken as 32 bits from the leading one down, its log2 is built one bit
    // per squaring, and the scaled product is rounded half away from zero.
    function automatic logic signed [LOSS_W-1:0] neg_log_q24(input logic [CONF_W-1:0] conf);
        int          msb;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] l2mag;
        logic [63:0] mag;
        msb = 0;
        for (int b = 0; b < CONF_W; b++) begin
            if (conf[b]) msb = b;
        end
        if (msb >= 31) mant = conf >> (msb - 31);
        else mant = conf << (31 - msb);
        frac = '0;
        for (int i = 0; i < LOG_FRAC_BITS; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        // Below 1.0 the loss is positive, above it the loss goes negative.
        if (msb < 32) l2mag = (64'(32 - msb) << LOG_FRAC_BITS) - frac;
        else l2mag = (64'(msb - 32) << LOG_FRAC_BITS) + frac;
        mag = (l2mag * 64'(LN2_Q30) + (64'd1 << 33)) >> 34;
        if (msb < 32) return mag[LOSS_W-1:0];
        return -mag[LOSS_W-1:0];
    endfunction

    // Scores one accepted class request against the current row and queues the
    // expected loss when the request closes its row.
    task automatic score_class(input class_req_t r);
        logic [PROB_W-1:0] p;
        logic [CONF_W:0]   sum;
        loss_res_t         res;
        p = r.prob;
        // The lower bound goes first, so crossed bounds leave clip_high in force.
        if (p < clip_lo) p = clip_lo;
        if (p > clip_hi) p = clip_hi;
        if (onehot_mode) begin
            if (r.label_bit) begin
                sum = {1'b0, row_conf} + p;
                row_conf = sum[CONF_W] ? {CONF_W{1'b1}} : sum[CONF_W-1:0];
            end
        end else if (row_pos < MAX_CLASSES && row_pos == r.true_class) begin
            // A later match in the same row replaces an earlier one.
            row_conf = p;
        end
        // Past the class limit the position stops, so no further index matches.
        if (row_pos < MAX_CLASSES) row_pos++;
        if (r.row_last) begin
            if (row_conf == '0) begin
                res.loss      = LOSS_MAX;
                res.saturated = 1'b1;
            end else begin
                res.loss      = neg_log_q24(row_conf);
                res.saturated = 1'b0;
            end
            expected_loss_q.push_back(res);
            row_conf = '0;
            row_pos  = 0;
            rows_scored++;
        end
    endtask

    // Request driver. A new request is loaded only when the channel is empty or
    // the current one is being taken, so valid and payload hold while stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                score_class(cur_req);
                requests_sent++;
            end
            if (!s_valid || s_ready) begin
                if (class_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_req       = class_req_q.pop_front();
                    s_valid      <= 1'b1;
                    s_prob       <= cur_req.prob;
                    s_label_bit  <= cur_req.label_bit;
                    s_true_class <= cur_req.true_class;
                    s_row_last   <= cur_req.row_last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every accepted result must match the oldest expected loss.
    always @(posedge aclk) begin
        loss_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_loss_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: loss %h saturated %b", m_loss, m_saturated);
                end else begin
                    want = expected_loss_q.pop_front();
                    if (m_loss !== want.loss || m_saturated !== want.saturated) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d mismatch: expected loss %h sat %b, got loss %h sat %b",
                                     results_checked, want.loss, want.saturated,
                                     m_loss, m_saturated);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog. Any request moving on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d losses outstanding",
                     STALL_LIMIT, expected_loss_q.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_req(input logic [PROB_W-1:0] prob, input logic label_bit,
                           input logic [CLASS_W-1:0] true_class, input logic row_last);
        class_req_t r;
        r.prob       = prob;
        r.label_bit  = label_bit;
        r.true_class = true_class;
        r.row_last   = row_last;
        class_req_q.push_back(r);
    endtask

    function automatic logic [PROB_W-1:0] rand_wide();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[PROB_W-1:0];
    endfunction

    // Half are probabilities below 2.0, mostly under 1.0, with tiny values, full-width values,
    // the extremes and values right at the clip bounds mixed in.
    function automatic logic [PROB_W-1:0] rand_prob();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return {23'd0, 1'($urandom_range(9) == 0), 32'($urandom)};
        if (pick < 65) return PROB_W'($urandom_range(1000));
        if (pick < 85) return rand_wide();
        if (pick < 90) return '0;
        if (pick < 95) return PROB_MAX;
        if (pick < 98) return clip_lo + PROB_W'($urandom_range(2)) - 56'd1;
        return clip_hi + PROB_W'($urandom_range(2)) - 56'd1;
    endfunction

    // Writes one register, called just after the clock rises. The request holds
    // until the block takes it, and the bench's copy follows as it is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LABEL_MODE: onehot_mode = val[0];
            CFG_CLIP_LOW:   clip_lo     = val;
            CFG_CLIP_HIGH:  clip_hi     = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic configure(input logic mode, input logic [PROB_W-1:0] lo,
                             input logic [PROB_W-1:0] hi);
        write_reg(CFG_LABEL_MODE, PROB_W'(mode));
        write_reg(CFG_CLIP_LOW, lo);
        write_reg(CFG_CLIP_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued request is taken and every expected loss has
    // come out, then lets the pipeline drain any row that yields no result.
    task automatic settle();
        while (class_req_q.size() != 0 || s_valid || expected_loss_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                 n;
        int                 len;
        int                 hot;
        int                 pick;
        bit                 tidy;
        logic [CLASS_W-1:0] tc;
        logic [PROB_W-1:0]  lo;
        logic [PROB_W-1:0]  hi;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, index mode with the reset clip bounds.
        // A zero prediction is lifted to the lower bound.
        add_req('0, 1'b0, 8'd0, 1'b1);
        // A full-scale prediction is cut down to the upper bound.
        add_req(PROB_MAX, 1'b1, 8'd0, 1'b1);
        // Exactly 1.0 on the true class gives a zero loss.
        add_req(ONE_Q32, 1'b0, 8'd0, 1'b0);
        add_req(PROB_MAX, 1'b0, 8'd0, 1'b1);
        // The true class lies past the end of the row, so the loss saturates.
        add_req(ONE_Q32, 1'b0, 8'd200, 1'b0);
        add_req(ONE_Q32, 1'b0, 8'd200, 1'b0);
        add_req(ONE_Q32, 1'b0, 8'd200, 1'b1);
        // The true class follows the position, so each request matches and the
        // last one wins.
        add_req(ONE_Q32 >> 1, 1'b0, 8'd0, 1'b0);
        add_req(ONE_Q32 >> 2, 1'b0, 8'd1, 1'b0);
        add_req(ONE_Q32 >> 3, 1'b0, 8'd2, 1'b1);
        // Open a row in index mode; it is finished in one-hot mode below.
        add_req(56'h1_2345_6789, 1'b1, 8'd1, 1'b0);
        add_req(ONE_Q32 >> 2, 1'b0, 8'd1, 1'b0);
        settle();

        // One-hot mode, clipping fully open, switched in the middle of a row.
        configure(1'b1, '0, PROB_MAX);
        add_req(ONE_Q32 >> 2, 1'b1, 8'd255, 1'b0);
        add_req(ONE_Q32 >> 3, 1'b0, 8'd255, 1'b0);
        add_req(ONE_Q32 >> 3, 1'b1, 8'd255, 1'b1);
        // No label bit set in the whole row.
        add_req(ONE_Q32, 1'b0, 8'd0, 1'b0);
        add_req(ONE_Q32, 1'b0, 8'd0, 1'b1);
        // A zero prediction with no lower bound leaves a zero confidence.
        add_req('0, 1'b1, 8'd0, 1'b1);
        // The smallest nonzero confidence gives the largest finite loss.
        add_req(56'd1, 1'b1, 8'd0, 1'b1);
        // Two full-scale labels give a large negative loss.
        add_req(PROB_MAX, 1'b1, 8'd0, 1'b0);
        add_req(PROB_MAX, 1'b1, 8'd0, 1'b1);
        settle();

        // Crossed bounds: the upper bound of 0.5 wins over the top lower bound.
        configure(1'b1, PROB_MAX, ONE_Q32 >> 1);
        add_req('0, 1'b1, 8'd0, 1'b0);
        add_req(PROB_MAX, 1'b1, 8'd0, 1'b1);
        settle();

        // An upper bound of zero clips everything to zero.
        configure(1'b0, 56'd5, '0);
        add_req(ONE_Q32, 1'b0, 8'd0, 1'b1);
        settle();

        // Random phases. The idle pattern rotates through none, sender only,
        // receiver only and both, while the label mode changes independently.
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(3))
                0:       lo = '0;
                1:       lo = CLIP_LOW_RST;
                2:       lo = PROB_W'($urandom_range(1 << 20));
                default: lo = rand_wide() >> $urandom_range(55);
            endcase
            case ($urandom_range(3))
                0:       hi = PROB_MAX;
                1:       hi = CLIP_HIGH_RST;
                2:       hi = ONE_Q32 + PROB_W'($urandom);
                default: hi = rand_wide() >> $urandom_range(40);
            endcase
            // The one-hot phase that carries the overflow row needs an open upper bound.
            if (ph == 1) hi = PROB_MAX;
            configure(1'((ph ^ (ph >> 2)) & 1), lo, hi);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
            endcase

            // The overflow row left open by the one-hot phase ends here in index
            // mode. Its position has stopped at the class limit, so none of these
            // requests match, not even where a wrapped position would point.
            if (ph == 2) begin
                for (int i = 0; i < 4; i++)
                    add_req(rand_prob(), 1'b1, 8'(MAX_CLASSES + 2 + i), i == 3);
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 10) len = 1;
                else len = $urandom_range(12, 2);
                // Most rows are well formed: one true class and one hot label,
                // now and then further labels. The rest are noise.
                tidy = ($urandom_range(99) < 80);
                tc   = 8'($urandom_range(len - 1));
                hot  = $urandom_range(len - 1);
                for (int i = 0; i < len; i++) begin
                    if (tidy)
                        add_req(rand_prob(), (i == hot) || ($urandom_range(9) == 0), tc,
                                i == len - 1);
                    else
                        add_req(rand_prob(), 1'($urandom_range(1)), 8'($urandom),
                                i == len - 1);
                end
                n += len;
            end

            // Enough full-scale labels to overflow the one-hot sum, in a row that
            // runs past the class limit and stays open into the next phase.
            if (ph == 1) begin
                for (int i = 0; i < MAX_CLASSES + 2; i++)
                    add_req(PROB_MAX, 1'b1, 8'($urandom), 1'b0);
            end
            settle();
        end

        $display("Sent %0d class requests in %0d rows with %0d register writes;",
                 requests_sent, rows_scored, cfg_writes);
        $display("checked %0d losses across directed cases and 8 random phases.",
                 results_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/celf_pkg.sv
sv/celf_front.sv
sv/celf_queue.sv
sv/celf_log_engine.sv
sv/cross_entropy_loss_forward.sv
sv/celf_checker.sv
test/testbench.sv
